// ----- hw/rtl/ggpd_pkg.sv -----
// Shared constants, field types and configuration layout of the ground-plane grid.
// Used by every ggpd_* module and by the ground_grid_plane_distance top level.
package ggpd_pkg;

  localparam int unsigned MAX_SIDE    = 64;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CELL_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COORD_W     = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W      = $clog2(MAX_SIDE + 1);

  localparam int unsigned DW      = 32;
  localparam int unsigned OFF_W   = DW + 1;
  localparam int unsigned BASE_W  = DW;
  localparam int unsigned ROI_W   = 31;
  localparam int unsigned INV_W   = 31;
  localparam int unsigned GC_W    = 7;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned SCALE_W = BASE_W + INV_W;
  localparam int unsigned K_W     = SCALE_W - 2 * FRAC_BITS;
  localparam int unsigned PROD_W  = DW + OFF_W;
  localparam int unsigned SUM_W   = PROD_W + 2;

  localparam int unsigned Q_DEPTH = 16;
  localparam int unsigned QP_W    = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W   = $clog2(Q_DEPTH + 1);

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [GC_W-1:0] GRID_CELLS_RST = GC_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CENTER_Z,
    CFG_ROI_X,
    CFG_ROI_Y,
    CFG_GRID_CELLS,
    CFG_INV_RES_X,
    CFG_INV_RES_Y
  } cfg_idx_e;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        cell_index;
    logic signed [DW-1:0]    normal_x;
    logic signed [DW-1:0]    normal_y;
    logic signed [DW-1:0]    normal_z;
    logic signed [DW-1:0]    plane_offset;
    logic                    ground_valid;
    logic signed [DW-1:0]    point_x;
    logic signed [DW-1:0]    point_y;
    logic signed [DW-1:0]    point_z;
  } ggpd_in_t;

  typedef struct packed {
    logic signed [DW-1:0] distance;
    logic                 inside_grid;
    logic                 has_ground;
  } ggpd_out_t;

  typedef struct packed {
    logic signed [DW-1:0] center_x;
    logic signed [DW-1:0] center_y;
    logic signed [DW-1:0] center_z;
    logic [ROI_W-1:0]     roi_x;
    logic [ROI_W-1:0]     roi_y;
    logic [GC_W-1:0]      grid_cells;
    logic [INV_W-1:0]     inv_res_x;
    logic [INV_W-1:0]     inv_res_y;
  } cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] nx;
    logic signed [DW-1:0] ny;
    logic signed [DW-1:0] nz;
    logic signed [DW-1:0] d;
  } plane_t;

  typedef struct packed {
    logic vld;
    logic query;
    logic in_roi;
  } tag_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] x;
    logic signed [OFF_W-1:0] y;
    logic signed [OFF_W-1:0] z;
  } offs_t;

  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] idx;
    plane_t            plane;
    logic              gv;
  } wr_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    plane_t            plane;
    logic              gv;
  } mem_req_t;

endpackage

// ----- hw/rtl/ggpd_front.sv -----
// Front pipeline: center offset, ROI test, column/row scaling and cell address.
// Depends on ggpd_pkg; feeds ggpd_store with one memory request per cycle.
module ggpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_acc_i,
  input  ggpd_pkg::ggpd_in_t  in_data_i,
  input  ggpd_pkg::cfg_t      cfg_i,
  output ggpd_pkg::tag_t      tag_o,
  output ggpd_pkg::offs_t     offs_o,
  output ggpd_pkg::mem_req_t  req_o
);
  import ggpd_pkg::*;

  localparam int unsigned RB_W = COORD_W + SIDE_W;

  tag_t  tag1_d, tag1_q, tag2_d, tag2_q, tag3_q, tag4_q;
  offs_t offs1_d, offs1_q, offs2_q, offs3_q, offs4_q;
  wr_t   wr1_d, wr1_q, wr2_q, wr3_q;

  logic signed [OFF_W-1:0] roi_x_s, roi_y_s, span_x, span_y;
  logic [BASE_W-1:0]       base_x2_q, base_y2_q;
  logic [SCALE_W-1:0]      scale_x, scale_y;
  logic [K_W-1:0]          kx3_q, ky3_q;
  logic [SIDE_W-1:0]       side;
  logic [COORD_W-1:0]      side_m1, col, row;
  logic [RB_W-1:0]         row_base;
  logic [CELL_W-1:0]       cell_addr;
  mem_req_t                req4_d, req4_q;
  logic                    we4_q;

  // stage 1: offset from grid center, exact in 33 bits
  always_comb begin
    tag1_d.vld    = in_acc_i;
    tag1_d.query  = (in_data_i.req_type == REQ_QUERY);
    tag1_d.in_roi = 1'b0;
    offs1_d.x = $signed({in_data_i.point_x[DW-1], in_data_i.point_x})
              - $signed({cfg_i.center_x[DW-1], cfg_i.center_x});
    offs1_d.y = $signed({in_data_i.point_y[DW-1], in_data_i.point_y})
              - $signed({cfg_i.center_y[DW-1], cfg_i.center_y});
    offs1_d.z = $signed({in_data_i.point_z[DW-1], in_data_i.point_z})
              - $signed({cfg_i.center_z[DW-1], cfg_i.center_z});
    wr1_d.ok       = (32'(in_data_i.cell_index) < STORE_DEPTH);
    wr1_d.idx      = CELL_W'(in_data_i.cell_index);
    wr1_d.plane.nx = in_data_i.normal_x;
    wr1_d.plane.ny = in_data_i.normal_y;
    wr1_d.plane.nz = in_data_i.normal_z;
    wr1_d.plane.d  = in_data_i.plane_offset;
    wr1_d.gv       = in_data_i.ground_valid;
  end

  // stage 2: ROI window check, shift into non-negative grid span
  assign roi_x_s = $signed(OFF_W'(cfg_i.roi_x));
  assign roi_y_s = $signed(OFF_W'(cfg_i.roi_y));
  assign span_x  = offs1_q.x + roi_x_s;
  assign span_y  = offs1_q.y + roi_y_s;

  always_comb begin
    tag2_d        = tag1_q;
    tag2_d.in_roi = (offs1_q.x >= -roi_x_s) && (offs1_q.x <= roi_x_s)
                 && (offs1_q.y >= -roi_y_s) && (offs1_q.y <= roi_y_s);
  end

  // stage 3: scale by cells per meter, drop both fraction fields
  assign scale_x = SCALE_W'(base_x2_q) * SCALE_W'(cfg_i.inv_res_x);
  assign scale_y = SCALE_W'(base_y2_q) * SCALE_W'(cfg_i.inv_res_y);

  // stage 4: clamp to the grid side, form row-major cell address
  always_comb begin
    if (cfg_i.grid_cells == '0) begin
      side = SIDE_W'(1);
    end else if (32'(cfg_i.grid_cells) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(cfg_i.grid_cells);
    end
  end

  assign side_m1   = COORD_W'(side - SIDE_W'(1));
  assign col       = (kx3_q > K_W'(side_m1)) ? side_m1 : COORD_W'(kx3_q);
  assign row       = (ky3_q > K_W'(side_m1)) ? side_m1 : COORD_W'(ky3_q);
  assign row_base  = RB_W'(row) * RB_W'(side);
  assign cell_addr = CELL_W'(row_base + RB_W'(col));

  always_comb begin
    req4_d.we    = tag3_q.vld && !tag3_q.query && wr3_q.ok;
    req4_d.addr  = tag3_q.query ? cell_addr : wr3_q.idx;
    req4_d.plane = wr3_q.plane;
    req4_d.gv    = wr3_q.gv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      we4_q  <= 1'b0;
    end else begin
      tag1_q <= tag1_d;
      tag2_q <= tag2_d;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      we4_q  <= req4_d.we;
    end
  end

  always_ff @(posedge clk_i) begin
    offs1_q   <= offs1_d;
    wr1_q     <= wr1_d;
    offs2_q   <= offs1_q;
    wr2_q     <= wr1_q;
    base_x2_q <= span_x[BASE_W-1:0];
    base_y2_q <= span_y[BASE_W-1:0];
    offs3_q   <= offs2_q;
    wr3_q     <= wr2_q;
    kx3_q     <= scale_x[SCALE_W-1:2*FRAC_BITS];
    ky3_q     <= scale_y[SCALE_W-1:2*FRAC_BITS];
    offs4_q   <= offs3_q;
    req4_q    <= req4_d;
  end

  always_comb begin
    req_o    = req4_q;
    req_o.we = we4_q;
  end

  assign tag_o  = tag4_q;
  assign offs_o = offs4_q;

endmodule

// ----- hw/rtl/ggpd_store.sv -----
// Cell store: plane memory and ground-valid memory, one access slot per cycle.
// Depends on ggpd_pkg; sweeps the valid memory clear after reset.
module ggpd_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ggpd_pkg::mem_req_t req_i,
  output ggpd_pkg::plane_t   plane_o,
  output logic               valid_o,
  output logic               busy_o
);
  import ggpd_pkg::*;

  plane_t            plane_mem [STORE_DEPTH];
  logic              valid_mem [STORE_DEPTH];
  plane_t            plane_rd_q;
  logic              valid_rd_q;
  logic [CELL_W-1:0] clr_addr_q;
  logic              clr_busy_q;

  // clearing sweep, one valid mark per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CELL_W'(1);
      if (clr_addr_q == CELL_W'(STORE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      plane_mem[req_i.addr] <= req_i.plane;
    end
    plane_rd_q <= plane_mem[req_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      valid_mem[clr_addr_q] <= 1'b0;
    end else if (req_i.we) begin
      valid_mem[req_i.addr] <= req_i.gv;
    end
    valid_rd_q <= valid_mem[req_i.addr];
  end

  assign plane_o = plane_rd_q;
  assign valid_o = valid_rd_q;
  assign busy_o  = clr_busy_q;

endmodule

// ----- hw/rtl/ggpd_dist.sv -----
// Distance back end: n.p products, exact sum, floor shift, offset add, saturate.
// Depends on ggpd_pkg; consumes the registered read data of ggpd_store.
module ggpd_dist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ggpd_pkg::tag_t      tag_i,
  input  ggpd_pkg::offs_t     offs_i,
  input  ggpd_pkg::plane_t    plane_i,
  input  logic                valid_i,
  output logic                res_vld_o,
  output ggpd_pkg::ggpd_out_t res_o
);
  import ggpd_pkg::*;

  tag_t  tag5_q, tag6_q, tag7_q;
  offs_t offs5_q;
  logic  has6_d, has6_q, has7_q, vld8_q;

  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [DW-1:0]     d6_q, d7_q;
  logic signed [SUM_W-1:0]  sum7_d, sum7_q, total;
  logic [SUM_W-DW:0]        hi_bits;
  logic signed [DW-1:0]     sat;
  ggpd_out_t                res8_d, res8_q;

  assign has6_d   = tag5_q.query && tag5_q.in_roi && valid_i;
  assign prod_x_d = plane_i.nx * offs5_q.x;
  assign prod_y_d = plane_i.ny * offs5_q.y;
  assign prod_z_d = plane_i.nz * offs5_q.z;

  assign sum7_d = prod_x_q + prod_y_q + prod_z_q;

  // floor of the Q32.32 sum back to Q16.16, then add d and clip to 32 bits
  assign total   = (sum7_q >>> FRAC_BITS) + SUM_W'(d7_q);
  assign hi_bits = total[SUM_W-1:DW-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      sat = total[DW-1:0];
    end else if (total[SUM_W-1]) begin
      sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DW-1){1'b1}}};
    end
    res8_d.distance    = has7_q ? sat : '0;
    res8_d.inside_grid = tag7_q.query && tag7_q.in_roi;
    res8_d.has_ground  = has7_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag5_q <= '0;
      tag6_q <= '0;
      tag7_q <= '0;
      has6_q <= 1'b0;
      has7_q <= 1'b0;
      vld8_q <= 1'b0;
    end else begin
      tag5_q <= tag_i;
      tag6_q <= tag5_q;
      tag7_q <= tag6_q;
      has6_q <= has6_d;
      has7_q <= has6_q;
      vld8_q <= tag7_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    offs5_q  <= offs_i;
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    prod_z_q <= prod_z_d;
    d6_q     <= plane_i.d;
    sum7_q   <= sum7_d;
    d7_q     <= d6_q;
    res8_q   <= res8_d;
  end

  assign res_vld_o = vld8_q;
  assign res_o     = res8_q;

endmodule

// ----- hw/rtl/ggpd_outq.sv -----
// Result queue with credit count: holds finished items while the receiver stalls.
// Depends on ggpd_pkg; full_o throttles input acceptance.
module ggpd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_acc_i,
  input  logic                wr_vld_i,
  input  ggpd_pkg::ggpd_out_t wr_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output ggpd_pkg::ggpd_out_t out_data_o,
  output logic                full_o
);
  import ggpd_pkg::*;

  ggpd_out_t          fifo_mem [Q_DEPTH];
  logic [QP_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   occ_q, credit_q;
  logic               out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_vld_i) begin
      fifo_mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      credit_q <= '0;
    end else begin
      if (wr_vld_i) begin
        wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
      end
      occ_q    <= occ_q + CNT_W'(wr_vld_i) - CNT_W'(out_acc);
      credit_q <= credit_q + CNT_W'(in_acc_i) - CNT_W'(out_acc);
    end
  end

  assign out_valid_o = (occ_q != '0);
  assign out_data_o  = fifo_mem[rd_ptr_q];
  assign full_o      = (credit_q == CNT_W'(Q_DEPTH));

endmodule

// ----- hw/rtl/ground_grid_plane_distance.sv -----
// Top level of the ground-plane grid distance block: config registers and pipeline.
// Depends on ggpd_pkg, ggpd_front, ggpd_store, ggpd_dist and ggpd_outq.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries write items
//   (req_type 0: fill one cell with normal, offset and ground mark) and query
//   items (req_type 1: a world point). Every item gives exactly one result on
//   the output channel (out_valid_o / out_stall_i / out_data_o), in order.
//   A query inside the ROI reads its cell and, when it holds a ground mark,
//   returns n.p + d, saturated. Throughput: one item per cycle whenever
//   in_stall_o is low; the plane memory is accessed once per item in a
//   single pipeline slot, so writes and reads stay in order. Pipeline:
//   9 register stages (4 front stages, memory read, products, sum,
//   offset/saturate, result queue).
//   Receiver stall: finished items wait in a 16-entry queue; a credit count
//   raises in_stall_o once 16 items are in flight or waiting, and the input
//   resumes as soon as the receiver takes items.
//   Reset: registers return to their reset values, then the valid memory is
//   swept clear across all 4096 cells with in_stall_o high; config writes are
//   taken throughout. Write config only while no item is in flight.
module ground_grid_plane_distance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ggpd_pkg::ggpd_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ggpd_pkg::ggpd_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ggpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ggpd_pkg::DW-1:0]       cfg_data_i
);
  import ggpd_pkg::*;

  cfg_t      cfg_q;
  logic      in_acc;
  logic      clr_busy, q_full;
  tag_t      tag4;
  offs_t     offs4;
  mem_req_t  mem_req;
  plane_t    plane_rd;
  logic      valid_rd;
  logic      res_vld;
  ggpd_out_t res;

  // hold input while the valid sweep runs or no credit is left
  assign in_stall_o = clr_busy || q_full;
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration registers, decoded by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_y   <= '0;
      cfg_q.center_z   <= '0;
      cfg_q.roi_x      <= '0;
      cfg_q.roi_y      <= '0;
      cfg_q.grid_cells <= GRID_CELLS_RST;
      cfg_q.inv_res_x  <= '0;
      cfg_q.inv_res_y  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:   cfg_q.center_x   <= cfg_data_i;
        CFG_CENTER_Y:   cfg_q.center_y   <= cfg_data_i;
        CFG_CENTER_Z:   cfg_q.center_z   <= cfg_data_i;
        CFG_ROI_X:      cfg_q.roi_x      <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_Y:      cfg_q.roi_y      <= cfg_data_i[ROI_W-1:0];
        CFG_GRID_CELLS: cfg_q.grid_cells <= cfg_data_i[GC_W-1:0];
        CFG_INV_RES_X:  cfg_q.inv_res_x  <= cfg_data_i[INV_W-1:0];
        CFG_INV_RES_Y:  cfg_q.inv_res_y  <= cfg_data_i[INV_W-1:0];
      endcase
    end
  end

  // offset, ROI test and cell address
  ggpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_acc_i  (in_acc),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .tag_o     (tag4),
    .offs_o    (offs4),
    .req_o     (mem_req)
  );

  // plane and valid memories; one write or read slot per item
  ggpd_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .plane_o (plane_rd),
    .valid_o (valid_rd),
    .busy_o  (clr_busy)
  );

  // dot product, floor shift and saturation
  ggpd_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag4),
    .offs_i    (offs4),
    .plane_i   (plane_rd),
    .valid_i   (valid_rd),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // result queue decouples receiver stall from the pipeline
  ggpd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .wr_vld_i    (res_vld),
    .wr_data_i   (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .full_o      (q_full)
  );

endmodule

// ----- hw/rtl/ggpd_checker.sv -----
// Port-level checks for ground_grid_plane_distance, attached by bind.
// Depends on ggpd_pkg for the channel payload types.
module ggpd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input ggpd_pkg::ggpd_out_t            out_data_o
);

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // the clearing sweep holds off input and output right after reset
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("item path open before valid sweep");

  // a ground hit needs a point inside the region
  a_ground_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_ground |-> out_data_o.inside_grid)
    else $error("ground reported outside region");

  // no ground, no distance
  a_zero_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_ground |-> out_data_o.distance == '0)
    else $error("distance nonzero without ground");

endmodule

bind ground_grid_plane_distance ggpd_checker u_ggpd_checker (.*);

// ----- tb/ground_grid_plane_distance_test.sv -----
// Self-checking testbench for ground_grid_plane_distance: random and directed plane writes
// and point queries, checked against an in-bench predictor of the grid. Depends on ggpd_pkg.
module ground_grid_plane_distance_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ggpd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000; // covers the valid-memory sweep after reset
  localparam int unsigned IDLE_PCT    = 9;
  localparam int unsigned PRINT_CAP   = 40;
  localparam logic [DW-1:0] ONE_M     = 32'h0001_0000;
  localparam logic signed [71:0] DIST_MAX = 72'sd2147483647;
  localparam logic signed [71:0] DIST_MIN = -72'sd2147483648;

  typedef enum {ROI_SPREAD, ROI_TINY, ROI_NONE, ROI_FULL} roi_kind_e;
  typedef enum {RES_MATCHED, RES_ZERO, RES_FULL} res_kind_e;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  ggpd_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ggpd_out_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_CENTER_X;
  logic [DW-1:0]        cfg_data_i  = '0;

  ground_grid_plane_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the registers and of the plane grid.
  logic signed [DW-1:0] ctr_x = '0, ctr_y = '0, ctr_z = '0;
  logic [ROI_W-1:0]     half_x = '0, half_y = '0;
  logic [GC_W-1:0]      side_reg = GRID_CELLS_RST;
  logic [INV_W-1:0]     per_m_x = '0, per_m_y = '0;
  plane_t               plane_mem [STORE_DEPTH];
  bit                   ground_mem [STORE_DEPTH]; // marks start cleared, as after reset

  ggpd_in_t    queued_requests [$];
  ggpd_out_t   awaited_answers [$];
  int unsigned filled_cells [$];

  bit          calm;
  int unsigned errors, writes_in, queries_in, inside_seen, ground_seen, settings_used;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Zero cells act as one, anything past the maximum acts as the maximum.
  function automatic int unsigned grid_side(logic [GC_W-1:0] cells);
    if (cells == 0) return 1;
    if (cells > MAX_SIDE) return MAX_SIDE;
    return cells;
  endfunction

  // Column or row: floor((offset + roi) * inv / 2^32), clamped to the last cell.
  function automatic int unsigned grid_coord(longint ofs, logic [ROI_W-1:0] half,
                                             logic [INV_W-1:0] per_m);
    logic [63:0] base, k;
    int unsigned last;
    last = grid_side(side_reg) - 1;
    base = 64'(ofs + longint'(half));
    k    = (base * 64'(per_m)) >> (2 * FRAC_BITS);
    if (k > last) return last;
    return k[31:0];
  endfunction

  // Apply one accepted item to the shadow grid and return the result it must produce.
  function automatic ggpd_out_t answer_for(ggpd_in_t rq);
    ggpd_out_t         ans;
    longint            ox, oy, oz;
    int unsigned       slot;
    plane_t            pl;
    logic signed [71:0] acc, term, ext;
    ans = '0;
    if (rq.req_type == REQ_WRITE) begin
      plane_mem[rq.cell_index]  = '{rq.normal_x, rq.normal_y, rq.normal_z, rq.plane_offset};
      ground_mem[rq.cell_index] = rq.ground_valid;
      return ans;
    end
    ox = longint'(rq.point_x) - longint'(ctr_x);
    oy = longint'(rq.point_y) - longint'(ctr_y);
    oz = longint'(rq.point_z) - longint'(ctr_z);
    if (ox < -longint'(half_x) || ox > longint'(half_x) ||
        oy < -longint'(half_y) || oy > longint'(half_y)) return ans;
    ans.inside_grid = 1'b1;
    slot = grid_coord(oy, half_y, per_m_y) * grid_side(side_reg)
         + grid_coord(ox, half_x, per_m_x);
    if (!ground_mem[slot]) return ans;
    pl  = plane_mem[slot];
    // Exact dot product, then floor toward minus infinity, add d and saturate.
    term = pl.nx; ext = ox; acc = term * ext;
    term = pl.ny; ext = oy; acc = acc + term * ext;
    term = pl.nz; ext = oz; acc = acc + term * ext;
    term = pl.d;
    acc  = (acc >>> FRAC_BITS) + term;
    if (acc > DIST_MAX) acc = DIST_MAX;
    if (acc < DIST_MIN) acc = DIST_MIN;
    ans.distance   = acc[DW-1:0];
    ans.has_ground = 1'b1;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued items, hold a stalled item, idle now and then.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      awaited_answers.push_back(answer_for(in_data_i));
      if (in_data_i.req_type == REQ_WRITE) writes_in++;
      else queries_in++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data_i  <= queued_requests.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    ggpd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_answers.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: result with nothing expected, expected none, got %p",
                   $time, out_data_o);
      end else begin
        want = awaited_answers.pop_front();
        if (want.inside_grid) inside_seen++;
        if (want.has_ground) ground_seen++;
        if (out_data_o.distance !== want.distance) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: distance mismatch, expected %0d, got %0d",
                     $time, want.distance, out_data_o.distance);
        end
        if (out_data_o.inside_grid !== want.inside_grid) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: inside_grid mismatch, expected %0b, got %0b",
                     $time, want.inside_grid, out_data_o.inside_grid);
        end
        if (out_data_o.has_ground !== want.has_ground) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: has_ground mismatch, expected %0b, got %0b",
                     $time, want.has_ground, out_data_o.has_ground);
        end
      end
    end
    out_stall_i <= !calm && $urandom_range(99) < IDLE_PCT;
  end

  // Watchdog: end the run when no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic program_grid(logic signed [DW-1:0] cx, cy, cz, logic [ROI_W-1:0] hx, hy,
                              logic [GC_W-1:0] cells, logic [INV_W-1:0] ix, iy);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_ROI_X, DW'(hx));
    write_reg(CFG_ROI_Y, DW'(hy));
    write_reg(CFG_GRID_CELLS, DW'(cells));
    write_reg(CFG_INV_RES_X, DW'(ix));
    write_reg(CFG_INV_RES_Y, DW'(iy));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ctr_x = cx; ctr_y = cy; ctr_z = cz;
    half_x = hx; half_y = hy;
    side_reg = cells;
    per_m_x = ix; per_m_y = iy;
    settings_used++;
  endtask

  // Wait until every item is accepted and every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || awaited_answers.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic ask(logic [DW-1:0] x, y, z);
    ggpd_in_t it;
    it          = '0;
    it.req_type = REQ_QUERY;
    it.point_x  = x;
    it.point_y  = y;
    it.point_z  = z;
    queued_requests.push_back(it);
  endtask

  task automatic put_plane(logic [IDX_W-1:0] idx, logic [DW-1:0] nx, ny, nz, d, logic gv);
    ggpd_in_t it;
    it              = '0;
    it.req_type     = REQ_WRITE;
    it.cell_index   = idx;
    it.normal_x     = nx;
    it.normal_y     = ny;
    it.normal_z     = nz;
    it.plane_offset = d;
    it.ground_valid = gv;
    queued_requests.push_back(it);
  endtask

  // Columns per meter that make the grid span exactly twice the ROI.
  function automatic logic [INV_W-1:0] cells_per_m(int unsigned side, logic [ROI_W-1:0] half);
    longint q;
    if (half == 0) return '1;
    q = (longint'(side) << 31) / longint'(half);
    return (q > 64'sh7FFF_FFFF) ? '1 : q[INV_W-1:0];
  endfunction

  // Center plus offset, pinned to the 32-bit range.
  function automatic logic [DW-1:0] near(logic signed [DW-1:0] c, longint ofs);
    longint pt;
    pt = longint'(c) + ofs;
    if (pt > 64'sd2147483647) pt = 64'sd2147483647;
    if (pt < -64'sd2147483648) pt = -64'sd2147483648;
    return pt[DW-1:0];
  endfunction

  // Offset anywhere in the ROI, on either edge, or one step past it.
  function automatic longint roi_offset(logic [ROI_W-1:0] half);
    case ($urandom_range(9))
      0: return longint'(half);
      1: return -longint'(half);
      2: return longint'(half) + 1;
      default: return longint'($urandom_range(2 * half)) - longint'(half);
    endcase
  endfunction

  // Offset of the middle of cell k along one axis.
  function automatic longint cell_offset(int unsigned k, logic [ROI_W-1:0] half,
                                         int unsigned side);
    return (longint'(half) * longint'(2 * k + 1)) / longint'(side) - longint'(half);
  endfunction

  // Mostly writes into the grid in use and queries aimed at filled cells; the rest noise.
  task automatic fill_random(int unsigned count);
    ggpd_in_t    it;
    int unsigned side, pick, c;
    filled_cells.delete();
    side = grid_side(side_reg);
    repeat (count) begin
      it.cell_index   = IDX_W'($urandom);
      it.normal_x     = $urandom;
      it.normal_y     = $urandom;
      it.normal_z     = $urandom;
      it.plane_offset = $urandom;
      it.ground_valid = 1'($urandom);
      it.point_x      = $urandom;
      it.point_y      = $urandom;
      it.point_z      = $urandom;
      pick = $urandom_range(99);
      if (pick < 35) begin
        it.req_type = REQ_WRITE;
        if (pick < 30) it.cell_index = IDX_W'($urandom_range(side * side - 1));
        if ($urandom_range(1)) begin
          // Normals near unit length
          it.normal_x = $urandom_range(32'h0002_0000) - 32'h0001_0000;
          it.normal_y = $urandom_range(32'h0002_0000) - 32'h0001_0000;
          it.normal_z = $urandom_range(32'h0002_0000) - 32'h0001_0000;
        end
        if ($urandom_range(1)) it.plane_offset = $urandom_range(32'h0040_0000) - 32'h0020_0000;
        it.ground_valid = $urandom_range(99) < 80;
        if (it.ground_valid && it.cell_index < side * side)
          filled_cells.push_back(it.cell_index);
      end else begin
        it.req_type = REQ_QUERY;
        if (pick < 65 && filled_cells.size() != 0) begin
          c = filled_cells[$urandom_range(filled_cells.size() - 1)];
          it.point_x = near(ctr_x, cell_offset(c % side, half_x, side));
          it.point_y = near(ctr_y, cell_offset(c / side, half_y, side));
        end else if (pick < 92) begin
          it.point_x = near(ctr_x, roi_offset(half_x));
          it.point_y = near(ctr_y, roi_offset(half_y));
        end
        if ($urandom_range(1))
          it.point_z = near(ctr_z, longint'($urandom_range(32'h0040_0000)) - 64'sh20_0000);
      end
      queued_requests.push_back(it);
    end
  endtask

  // One grid setting: program registers, stream items, drain.
  task automatic random_phase(logic [GC_W-1:0] cells, roi_kind_e rk, res_kind_e ik,
                              bit wild, bit steady, int unsigned count);
    logic signed [DW-1:0] c [3];
    logic [ROI_W-1:0]     h [2];
    logic [INV_W-1:0]     r [2];
    foreach (c[i]) begin
      if (wild) begin
        case ($urandom_range(2))
          0: c[i] = 32'h8000_0000;
          1: c[i] = 32'h7FFF_FFFF;
          default: c[i] = $urandom;
        endcase
      end else begin
        c[i] = $urandom_range(32'h0200_0000) - 32'h0100_0000;
      end
    end
    foreach (h[i]) begin
      case (rk)
        ROI_SPREAD: h[i] = ROI_W'($urandom_range(32'h007F_FFFF, 32'h0001_0000));
        ROI_TINY:   h[i] = ROI_W'($urandom_range(255, 1));
        ROI_NONE:   h[i] = '0;
        default:    h[i] = '1;
      endcase
    end
    foreach (r[i]) begin
      case (ik)
        RES_MATCHED: r[i] = cells_per_m(grid_side(cells), h[i]);
        RES_ZERO:    r[i] = '0;
        default:     r[i] = '1;
      endcase
    end
    program_grid(c[0], c[1], c[2], h[0], h[1], cells, r[0], r[1]);
    calm = steady;
    fill_random(count);
    wait_idle();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 4x4 grid spanning -4 m..+4 m, 2 m per cell, centered at the origin.
    program_grid('0, '0, '0, 31'h4_0000, 31'h4_0000, 7'd4, 31'h8000, 31'h8000);
    ask('0, '0, '0);                                    // cell never marked
    ask(32'h0004_0001, '0, '0);                         // one LSB past +x edge
    ask('0, 32'hFFFB_FFFF, '0);                         // one LSB past -y edge
    ask(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);   // most negative point
    ask(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // most positive point
    ask(32'h0004_0000, 32'hFFFC_0000, '0);              // both edges inclusive, col clamps
    put_plane(12'd0, '0, '0, ONE_M, '0, 1'b1);          // flat ground at z = 0
    ask(32'hFFFC_0000, 32'hFFFC_0000, 32'h0002_0000);   // 2 m above
    ask(32'hFFFC_0000, 32'hFFFC_0000, 32'hFFFD_0000);   // 3 m below
    put_plane(12'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    ask(32'h0004_0000, 32'h0004_0000, 32'h7FFF_FFFF);   // saturate high in the far corner
    put_plane(12'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    ask(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);   // saturate low
    put_plane(12'd6, '0, '0, 32'h1, '0, 1'b1);          // tiny normal to expose rounding
    ask(32'h0000_8000, 32'hFFFF_0000, 32'hFFFF_FFFF);   // -1 LSB floors to -1
    ask(32'h0000_8000, 32'hFFFF_0000, 32'h0000_0001);   // +1 LSB floors to 0
    put_plane(12'd6, '0, '0, 32'h1, '0, 1'b0);          // drop the ground mark
    ask(32'h0000_8000, 32'hFFFF_0000, 32'hFFFF_FFFF);
    put_plane(12'hFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    put_plane(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    put_plane(12'h555, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0, 1'b0);
    wait_idle();

    // Random: several settings, extremes among them; the 4x4 one runs without idling.
    random_phase(7'd8,   ROI_SPREAD, RES_MATCHED, 1'b0, 1'b0, 250);
    random_phase(7'd4,   ROI_SPREAD, RES_MATCHED, 1'b0, 1'b1, 250);
    random_phase(7'd64,  ROI_SPREAD, RES_MATCHED, 1'b0, 1'b0, 250);
    random_phase(7'd0,   ROI_SPREAD, RES_MATCHED, 1'b0, 1'b0, 120);
    random_phase(7'd127, ROI_TINY,   RES_FULL,    1'b0, 1'b0, 150);
    random_phase(7'd16,  ROI_SPREAD, RES_ZERO,    1'b0, 1'b0, 120);
    random_phase(7'd64,  ROI_FULL,   RES_MATCHED, 1'b1, 1'b0, 200);
    random_phase(7'd2,   ROI_NONE,   RES_MATCHED, 1'b0, 1'b0, 120);
    random_phase(7'd1,   ROI_SPREAD, RES_MATCHED, 1'b1, 1'b0, 120);
    random_phase(7'd32,  ROI_SPREAD, RES_MATCHED, 1'b0, 1'b0, 250);

    // Let the pipeline run dry to catch stray results.
    repeat (32) @(posedge clk_i);

    $display("Covered %0d plane writes and %0d queries over %0d grid settings.",
             writes_in, queries_in, settings_used);
    $display("%0d queries fell inside the ROI, %0d of them on marked ground.",
             inside_seen, ground_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ggpd_pkg.sv
hw/rtl/ggpd_front.sv
hw/rtl/ggpd_store.sv
hw/rtl/ggpd_dist.sv
hw/rtl/ggpd_outq.sv
hw/rtl/ground_grid_plane_distance.sv
hw/rtl/ggpd_checker.sv
tb/ground_grid_plane_distance_test.sv
